// ----- sv/rsls_pkg.sv -----
// Package: shared widths, codes and reset values of the rectangle survey leg sequencer.
package rsls_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 24;
	localparam int unsigned GRID_W          = 20;
	localparam int unsigned TOL_W           = 15;
	localparam int unsigned COURSE_W        = 16;
	localparam int unsigned SHIFT_W         = GRID_W + 1;
	localparam int unsigned CFG_ADDR_W      = 2;
	localparam int unsigned CFG_DATA_W      = GRID_W;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_LINE   = 2'd1,
		CMD_CIRCLE = 2'd2
	} cmd_t;

	typedef enum logic {
		MODE_START = 1'b0,
		MODE_STEP  = 1'b1
	} mode_t;

	localparam logic [CFG_ADDR_W-1:0] REG_ORIENTATION = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GRID        = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE   = 2'd2;

	localparam logic              ORIENT_RST = 1'b0;
	localparam logic [GRID_W-1:0] GRID_RST   = 20'd1600;
	localparam logic [TOL_W-1:0]  TOL_RST    = 15'd1820;

	localparam logic [COURSE_W-1:0] TURN_NORTH = 16'd0;
	localparam logic [COURSE_W-1:0] TURN_EAST  = 16'd16384;
	localparam logic [COURSE_W-1:0] TURN_SOUTH = 16'd32768;
	localparam logic [COURSE_W-1:0] TURN_WEST  = 16'd49152;
	localparam logic [COURSE_W:0]   TURN_FULL  = 17'h10000;

endpackage

// ----- sv/rsls_if.sv -----
// Interfaces: item, result and configuration channels of the survey leg sequencer.
interface rsls_item_if import rsls_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic signed [COORD_WIDTH-1:0] corner_a_x;
	logic signed [COORD_WIDTH-1:0] corner_a_y;
	logic signed [COORD_WIDTH-1:0] corner_b_x;
	logic signed [COORD_WIDTH-1:0] corner_b_y;
	logic signed [COORD_WIDTH-1:0] pos_x;
	logic signed [COORD_WIDTH-1:0] pos_y;
	logic [COURSE_W-1:0]           course;

	modport source (output valid, mode, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
		pos_x, pos_y, course, input ready);
	modport sink (input valid, mode, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
		pos_x, pos_y, course, output ready);
endinterface

interface rsls_result_if import rsls_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic signed [COORD_WIDTH-1:0] line_from_x;
	logic signed [COORD_WIDTH-1:0] line_from_y;
	logic signed [COORD_WIDTH-1:0] line_to_x;
	logic signed [COORD_WIDTH-1:0] line_to_y;
	logic signed [COORD_WIDTH-1:0] circle_x;
	logic signed [COORD_WIDTH-1:0] circle_y;
	logic signed [COORD_WIDTH-1:0] circle_radius;
	logic                          line_start;
	logic                          line_stop;
	logic                          turning;

	modport source (output valid, command, line_from_x, line_from_y, line_to_x, line_to_y,
		circle_x, circle_y, circle_radius, line_start, line_stop, turning, input ready);
	modport sink (input valid, command, line_from_x, line_from_y, line_to_x, line_to_y,
		circle_x, circle_y, circle_radius, line_start, line_stop, turning, output ready);
endinterface

interface rsls_cfg_if import rsls_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// ----- sv/rectangle_survey_leg_sequencer.sv -----
// Top level: boustrophedon survey leg sequencer, one navigation step per item.
// Flow: an accepted item is held in the input register and worked there combinationally;
// its result is registered in the leg state and result register. Throughput: one item per
// cycle unless result_out stalls, set by the single pass from input to result register.
// Reset: leg, shift, circle and U-turn state clear to zero, registers take their defaults.
module rectangle_survey_leg_sequencer import rsls_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rsls_cfg_if.sink      cfg,
	rsls_item_if.sink     item_in,
	rsls_result_if.source result_out
);

	localparam int unsigned CW = COORD_WIDTH;
	localparam int unsigned EW = ((CW > SHIFT_W) ? CW : SHIFT_W) + 3;
	localparam logic signed [EW-1:0] C_MAX_E = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [EW-1:0] C_MIN_E = ~C_MAX_E;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [EW-1:0] wide_t;

	function automatic wide_t ext_c(input coord_t v);
		return EW'(v);
	endfunction

	function automatic coord_t sat_c(input wide_t v);
		wide_t r;
		r = (v > C_MAX_E) ? C_MAX_E : ((v < C_MIN_E) ? C_MIN_E : v);
		return r[CW-1:0];
	endfunction

	// halve, truncating toward zero
	function automatic wide_t half_e(input wide_t v);
		return (v + $signed({{(EW-1){1'b0}}, v[EW-1]})) >>> 1;
	endfunction

	function automatic logic close_to(input logic [COURSE_W-1:0] crs,
		input logic [COURSE_W-1:0] tgt, input logic [TOL_W-1:0] tol);
		logic [COURSE_W-1:0] d;
		d = tgt - crs;
		return ({1'b0, d} < {2'b00, tol}) || ({1'b0, d} > (TURN_FULL - {2'b00, tol}));
	endfunction

	// configuration
	logic              orient_q;
	logic [GRID_W-1:0] grid_q;
	logic [TOL_W-1:0]  tol_q;

	// input register
	logic                valid_s1;
	logic                mode_s1;
	coord_t              ax_s1, ay_s1, bx_s1, by_s1, px_s1, py_s1;
	logic [COURSE_W-1:0] course_s1;

	// leg state, doubles as the result payload
	coord_t                    from_x_q, from_y_q, to_x_q, to_y_q, cen_x_q, cen_y_q;
	logic signed [SHIFT_W-1:0] shift_q, radius_q;
	logic                      uturn_q;

	// result register
	logic out_valid_q;
	cmd_t cmd_q;
	logic start_q, stop_q;

	logic adv, in_ready;

	// next state
	coord_t                    n_fx, n_fy, n_tx, n_ty, n_cx, n_cy;
	coord_t                    l_fx, l_fy, l_tx, l_ty;
	logic signed [SHIFT_W-1:0] n_shift, n_rad;
	logic                      n_uturn, n_start, n_stop;
	cmd_t                      n_cmd;

	coord_t west, east, south, north, cn, cen, lo_c, hi_c;
	logic   gn, gs, ge, gw, follow, finish;
	wide_t  half_grid, lo_e, hi_e, clamp, c_e, trial, c2, sh2, rad;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= ORIENT_RST;
			grid_q   <= GRID_RST;
			tol_q    <= TOL_RST;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_ORIENTATION: orient_q <= cfg.data[0];
				REG_GRID:        grid_q   <= cfg.data[GRID_W-1:0];
				REG_TOLERANCE:   tol_q    <= cfg.data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv              = valid_s1 && (!out_valid_q || result_out.ready);
	assign in_ready         = !valid_s1 || adv;
	assign item_in.ready    = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && item_in.valid) begin
			mode_s1   <= item_in.mode;
			ax_s1     <= item_in.corner_a_x;
			ay_s1     <= item_in.corner_a_y;
			bx_s1     <= item_in.corner_b_x;
			by_s1     <= item_in.corner_b_y;
			px_s1     <= item_in.pos_x;
			py_s1     <= item_in.pos_y;
			course_s1 <= item_in.course;
		end
	end

	always_comb begin
		west  = (ax_s1 < bx_s1) ? ax_s1 : bx_s1;
		east  = (ax_s1 < bx_s1) ? bx_s1 : ax_s1;
		south = (ay_s1 < by_s1) ? ay_s1 : by_s1;
		north = (ay_s1 < by_s1) ? by_s1 : ay_s1;

		gn = !orient_q && (to_y_q > from_y_q);
		gs = !orient_q && (to_y_q < from_y_q);
		ge = orient_q && (to_x_q > from_x_q);
		gw = orient_q && (to_x_q < from_x_q);

		follow = (py_s1 < north && gn) || (py_s1 > south && gs) ||
			(px_s1 < east && ge) || (px_s1 > west && gw);
		finish = (gn && close_to(course_s1, TURN_NORTH, tol_q)) ||
			(gs && close_to(course_s1, TURN_SOUTH, tol_q)) ||
			(ge && close_to(course_s1, TURN_EAST, tol_q)) ||
			(gw && close_to(course_s1, TURN_WEST, tol_q));

		l_fx = from_x_q;
		l_fy = from_y_q;
		l_tx = to_x_q;
		l_ty = to_y_q;
		if (gn) begin
			l_ty = north;
			l_fy = south;
		end else if (gs) begin
			l_ty = south;
			l_fy = north;
		end else if (ge) begin
			l_tx = east;
			l_fx = west;
		end else if (gw) begin
			l_tx = west;
			l_fx = east;
		end

		half_grid = $signed(EW'(grid_q >> 1));
		lo_e      = '0;
		hi_e      = '0;
		clamp     = '0;
		lo_c      = orient_q ? south : west;
		hi_c      = orient_q ? north : east;
		c_e       = orient_q ? ext_c(l_fy) : ext_c(l_fx);
		trial     = c_e + EW'(shift_q);
		c2        = c_e;
		sh2       = EW'(shift_q);
		if (trial < ext_c(lo_c) || trial > ext_c(hi_c)) begin
			c2  = c_e + half_e(EW'(shift_q));
			sh2 = -EW'(shift_q);
		end
		cn  = sat_c(c2 + sh2);
		cen = sat_c(ext_c(cn) - half_e(sh2));
		rad = half_e(sh2);

		n_fx    = from_x_q;
		n_fy    = from_y_q;
		n_tx    = to_x_q;
		n_ty    = to_y_q;
		n_cx    = cen_x_q;
		n_cy    = cen_y_q;
		n_shift = shift_q;
		n_rad   = radius_q;
		n_uturn = uturn_q;
		n_cmd   = CMD_NONE;
		n_start = 1'b0;
		n_stop  = 1'b0;

		if (mode_s1 == MODE_START) begin
			if (!orient_q) begin
				lo_e  = ext_c(west) + half_grid;
				hi_e  = ext_c(east) - half_grid;
				clamp = (ext_c(px_s1) > lo_e) ? ext_c(px_s1) : lo_e;
				clamp = (clamp < hi_e) ? clamp : hi_e;
				n_fx  = sat_c(clamp);
				n_tx  = sat_c(clamp);
				if (py_s1 > north || (py_s1 > south && course_s1 > TURN_EAST &&
					course_s1 < TURN_WEST)) begin
					n_fy = north;
					n_ty = south;
				end else begin
					n_fy = south;
					n_ty = north;
				end
			end else begin
				lo_e  = ext_c(south) + half_grid;
				hi_e  = ext_c(north) - half_grid;
				clamp = (ext_c(py_s1) > lo_e) ? ext_c(py_s1) : lo_e;
				clamp = (clamp < hi_e) ? clamp : hi_e;
				n_fy  = sat_c(clamp);
				n_ty  = sat_c(clamp);
				if (px_s1 > east || (px_s1 > west && course_s1 > TURN_SOUTH)) begin
					n_fx = east;
					n_tx = west;
				end else begin
					n_fx = west;
					n_tx = east;
				end
			end
			n_shift = $signed({1'b0, grid_q});
			n_uturn = 1'b0;
			n_start = 1'b1;
		end else begin
			n_fx = l_fx;
			n_fy = l_fy;
			n_tx = l_tx;
			n_ty = l_ty;
			if (!uturn_q) begin
				if (follow) begin
					n_cmd = CMD_LINE;
				end else begin
					if (!orient_q) begin
						n_fx = cn;
						n_tx = cn;
						n_fy = l_ty;
						n_ty = l_fy;
						n_cx = cen;
						n_cy = l_ty;
						if (l_fy > l_ty) begin
							rad = -rad;
						end
					end else begin
						n_fy = cn;
						n_ty = cn;
						n_fx = l_tx;
						n_tx = l_fx;
						n_cx = l_tx;
						n_cy = cen;
						if (l_fx < l_tx) begin
							rad = -rad;
						end
					end
					n_shift = sh2[SHIFT_W-1:0];
					n_rad   = rad[SHIFT_W-1:0];
					n_uturn = 1'b1;
					n_stop  = 1'b1;
				end
			end else if (finish) begin
				n_uturn = 1'b0;
				n_start = 1'b1;
			end else begin
				n_cmd = CMD_CIRCLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			from_x_q    <= '0;
			from_y_q    <= '0;
			to_x_q      <= '0;
			to_y_q      <= '0;
			cen_x_q     <= '0;
			cen_y_q     <= '0;
			shift_q     <= '0;
			radius_q    <= '0;
			uturn_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cmd_q       <= CMD_NONE;
			start_q     <= 1'b0;
			stop_q      <= 1'b0;
		end else if (adv) begin
			from_x_q    <= n_fx;
			from_y_q    <= n_fy;
			to_x_q      <= n_tx;
			to_y_q      <= n_ty;
			cen_x_q     <= n_cx;
			cen_y_q     <= n_cy;
			shift_q     <= n_shift;
			radius_q    <= n_rad;
			uturn_q     <= n_uturn;
			out_valid_q <= 1'b1;
			cmd_q       <= n_cmd;
			start_q     <= n_start;
			stop_q      <= n_stop;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	wide_t radius_e;
	assign radius_e = EW'(radius_q);

	assign result_out.valid         = out_valid_q;
	assign result_out.command       = cmd_q;
	assign result_out.line_from_x   = from_x_q;
	assign result_out.line_from_y   = from_y_q;
	assign result_out.line_to_x     = to_x_q;
	assign result_out.line_to_y     = to_y_q;
	assign result_out.circle_x      = cen_x_q;
	assign result_out.circle_y      = cen_y_q;
	assign result_out.circle_radius = radius_e[CW-1:0];
	assign result_out.line_start    = start_q;
	assign result_out.line_stop     = stop_q;
	assign result_out.turning       = uturn_q;

endmodule
